// File: rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // default pool size and block_count reset value
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int BC_RESET       = 64;

  // used-mark map is scanned one word per cycle
  localparam int WORD_LOG = 4;
  localparam int WORD_W   = 1 << WORD_LOG;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_INVALID   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // take the input beat
    logic scan_step;  // examine the current map word
    logic finish;     // commit the request and load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;  // incoming beat is an allocate with free blocks left
    logic hit;        // current map word holds a free block
    logic last_word;  // current map word is the last one
    logic out_free;   // result register can take a new result this cycle
  } dp_stat_t;

endpackage

// File: rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: accept, word-serial scan of the used map, commit.
// ----------------------------------------------------------------------------
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.need_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (stat.hit || stat.last_word) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = 1'b1;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/fbpa_dp.sv
// ----------------------------------------------------------------------------
// fbpa_dp
// Used-mark map, free count, block count, scan word counter, result register.
// ----------------------------------------------------------------------------
module fbpa_dp
  import fbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_block_count,
  input  logic       in_action,
  input  logic [5:0] in_block_index,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   stat,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [5:0] out_granted_index,
  output logic [6:0] out_free_blocks,
  output logic       out_exhausted
);

  localparam int NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int MARK_N = NWORDS * WORD_W;
  localparam int MIDX_W = $clog2(MARK_N);
  localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [7:0] MAX_B8 = 8'(MAX_BLOCKS);
  localparam logic [6:0] BC_RST =
    (MAX_BLOCKS < BC_RESET) ? 7'(MAX_BLOCKS) : 7'(BC_RESET);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);

  // control state
  logic [MARK_N-1:0] marks_r, marks_nxt;
  logic [6:0]        free_r, free_nxt;
  logic [6:0]        bc_r;
  logic              out_valid_r;

  // request and scan payload
  logic              act_r;
  logic [5:0]        idx_r;
  logic [WIDX_W-1:0] wcnt_r;
  logic              found_r;
  logic [MIDX_W-1:0] grant_r;

  // result payload
  logic [1:0] status_r, status_nxt;
  logic [5:0] gidx_r, gidx_nxt;
  logic [6:0] ofree_r;
  logic       oexh_r;

  // scan of one map word
  logic [MIDX_W-1:0]   word_base;
  logic [WORD_W-1:0]   scan_word;
  logic [WORD_W-1:0]   avail;
  logic                hit;
  logic [WORD_LOG-1:0] hit_pos;

  always_comb begin
    word_base = MIDX_W'(wcnt_r) << WORD_LOG;
    scan_word = marks_r[word_base +: WORD_W];
    for (int j = 0; j < WORD_W; j++) begin
      avail[j] = !scan_word[j] && ((9'(word_base) + 9'(j)) < {2'b00, bc_r});
    end
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (avail[j]) begin
        hit     = 1'b1;
        hit_pos = WORD_LOG'(j);
      end
    end
  end

  // block count write, clamped to the pool size
  logic [6:0] bc_wr;
  assign bc_wr = ({1'b0, cfg_block_count} > MAX_B8) ? 7'(MAX_BLOCKS) : cfg_block_count;

  // commit of the held request
  logic [7:0]        idx_ext;
  logic [MIDX_W-1:0] idx_sel;
  logic [7:0]        grant_ext;

  always_comb begin
    idx_ext    = {2'b00, idx_r};
    idx_sel    = idx_ext[MIDX_W-1:0];
    grant_ext  = 8'(grant_r);
    marks_nxt  = marks_r;
    free_nxt   = free_r;
    status_nxt = STAT_OK;
    gidx_nxt   = '0;
    if (!act_r) begin
      if (found_r) begin
        marks_nxt[grant_r] = 1'b1;
        free_nxt           = free_r - 7'd1;
        gidx_nxt           = grant_ext[5:0];
      end else begin
        status_nxt = STAT_EXHAUSTED;
      end
    end else begin
      if (idx_ext >= {1'b0, bc_r}) begin
        status_nxt = STAT_INVALID;
      end else if (marks_r[idx_sel]) begin
        marks_nxt[idx_sel] = 1'b0;
        free_nxt           = free_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r     <= '0;
      free_r      <= BC_RST;
      bc_r        <= BC_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        marks_r <= '0;
        free_r  <= bc_wr;
        bc_r    <= bc_wr;
      end else if (cmd.finish) begin
        marks_r <= marks_nxt;
        free_r  <= free_nxt;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r   <= in_action;
      idx_r   <= in_block_index;
      wcnt_r  <= '0;
      found_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (hit) begin
        found_r <= 1'b1;
        grant_r <= word_base | MIDX_W'(hit_pos);
      end else begin
        wcnt_r <= WIDX_W'(wcnt_r + 1'b1);
      end
    end
    if (cmd.finish) begin
      status_r <= status_nxt;
      gidx_r   <= gidx_nxt;
      ofree_r  <= free_nxt;
      oexh_r   <= (free_nxt == 7'd0);
    end
  end

  always_comb begin
    stat.need_scan = !in_action && (free_r != 7'd0);
    stat.hit       = hit;
    stat.last_word = (wcnt_r == LAST_WORD);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_index = gidx_r;
  assign out_free_blocks   = ofree_r;
  assign out_exhausted     = oexh_r;

  // free count tracks the map: marks outside the pool are never set
  a_free_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= bc_r)
    else $error("free count above block count");

  a_free_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(free_r) + $countones(marks_r)) == int'(bc_r))
    else $error("free count disagrees with used map");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("committed result not presented");

  a_exh_status_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == STAT_EXHAUSTED)) |-> oexh_r)
    else $error("exhausted status without exhausted flag");

endmodule

// File: rtl/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block pool allocator with a used-mark map and free count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per request. in_action 0
//   allocates the lowest-numbered free block, 1 releases in_block_index.
//   Result channel (out_valid / out_stall): exactly one beat per request with
//   status, granted index, free count after the request and exhausted flag.
//   Config: cfg_we with cfg_block_count sets the pool size (clamped to
//   MAX_BLOCKS) and frees every block; write it only while idle.
// Sequence:
//   A release is held in the request registers when accepted and is written
//   to the result register from the commit state once that register is free.
//   An allocate first scans the used map in 16-block words, one word per cycle,
//   up to the one holding a free block (at most 4 words for the default 64
//   blocks), then commits. Allocate on an empty pool skips the scan. One
//   request is in flight at a time; the next is taken while the previous
//   result waits in the output register.
// Reset (rst_n low, synchronous): all blocks free, block count and free
//   count = min(64, MAX_BLOCKS), no result pending.
// Stall: a stalled result holds; the block finishes the next request and
//   then waits before committing it, so in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic [6:0] cfg_block_count,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [5:0] in_block_index,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [5:0] out_granted_index,
  output logic [6:0] out_free_blocks,
  output logic       out_exhausted
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: idle / scan / commit
  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // map, counters and result register
  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_block_count   (cfg_block_count),
    .in_action         (in_action),
    .in_block_index    (in_block_index),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_blocks   (out_free_blocks),
    .out_exhausted     (out_exhausted)
  );

endmodule
